// ===== hdl/assert_macros.svh =====
// Assertion helpers. Every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/tfn_pkg.sv =====
package tfn_pkg;

    localparam int SQ_STEPS  = 35;   // root bits
    localparam int DIV_STEPS = 15;   // quotient bits
    localparam int MAG_W     = 34;
    localparam int SUM_W     = 70;
    localparam int LEN_W     = 35;
    localparam int SREM_W    = 38;
    localparam int NUM_W     = 49;
    localparam int DREM_W    = 36;
    localparam int QUO_W     = 15;

    localparam logic [15:0] MIN_LENGTH_RST = 16'd7;
    localparam logic [0:0]  REG_MIN_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic               last;
    } tfn_tri_t;

    // cross product as magnitude and sign
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  last;
    } tfn_vec_t;

    typedef struct packed {
        tfn_vec_t          vec;
        logic [SUM_W-1:0]  sum;
        logic [SREM_W-1:0] rem;
        logic [LEN_W-1:0]  root;
    } tfn_sq_t;

    typedef struct packed {
        tfn_vec_t               vec;
        logic [LEN_W-1:0]       len;
        logic [2:0][NUM_W-1:0]  num;
        logic [2:0][DREM_W-1:0] rem;
        logic [2:0][QUO_W-1:0]  quo;
    } tfn_dv_t;

    typedef struct packed {
        logic en;
        logic valid;
    } tfn_ctl_t;

endpackage

// ===== hdl/tfn_if.sv =====
interface tfn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic               last_face;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
                    output ready);
endinterface

interface tfn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
    logic               last_out;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, last_out,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, last_out,
                    output ready);
endinterface

// ===== hdl/triangle_face_normal_top.sv =====
// Channel    Dir   Payload                                      Handshake
// tri_in     in    ax..cz Q8.8, last_face                       valid/ready
// norm_out   out   normal_x/y/z Q1.14, degenerate, last_out     valid/ready
// apb        in    min_length at byte 0                         psel/penable
//
// One word per cycle in and out while the pipe is not held; 6 front stages,
// 35 root cells, 1 divider setup stage, 15 quotient cells, 1 output register.
// The whole pipe advances together; it holds only when the output register
// is full and norm_out is not ready, and then tri_in.ready drops.
// Reset clears all valid bits and sets min_length to 7; no clearing pass.
`include "assert_macros.svh"

module triangle_face_normal_top (
    input  logic        clk,
    input  logic        rst_n,
    tfn_in_if.sink      tri_in,
    tfn_out_if.source   norm_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfn_pkg::*;

    logic        en;
    tfn_ctl_t    ctl;
    tfn_tri_t    tri_d;
    logic [15:0] min_length_reg;

    logic        sq_v [SQ_STEPS+1];
    tfn_sq_t     sq_d [SQ_STEPS+1];
    logic        dv_v [DIV_STEPS+1];
    tfn_dv_t     dv_d [DIV_STEPS+1];
    tfn_dv_t     dv0_next;

    logic               degen_c;
    logic [34:0]        rs [3];
    logic [15:0]        pick [3];
    logic [15:0]        res [3];

    logic               ov_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic               dg_reg;
    logic               lo_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= MIN_LENGTH_RST;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_LENGTH)
            min_length_reg <= pwdata[15:0];
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_LENGTH: prdata = {16'd0, min_length_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // single enable for the whole chain; output register is the last stage
    assign en           = !ov_reg || norm_out.ready;
    assign tri_in.ready = en;
    assign ctl.en       = en;
    assign ctl.valid    = tri_in.valid;

    assign tri_d.ax   = tri_in.ax;
    assign tri_d.ay   = tri_in.ay;
    assign tri_d.az   = tri_in.az;
    assign tri_d.bx   = tri_in.bx;
    assign tri_d.by   = tri_in.by;
    assign tri_d.bz   = tri_in.bz;
    assign tri_d.cx   = tri_in.cx;
    assign tri_d.cy   = tri_in.cy;
    assign tri_d.cz   = tri_in.cz;
    assign tri_d.last = tri_in.last_face;

    // edges, cross product, squared length
    tfn_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .tri_d (tri_d),
        .vout  (sq_v[0]),
        .dout  (sq_d[0])
    );

    // integer square root, one bit per cell
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        tfn_sq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (sq_v[k]),
            .din   (sq_d[k]),
            .vout  (sq_v[k+1]),
            .dout  (sq_d[k+1])
        );
    end

    // divider setup: numerator = mag*2^14 + len/2, top bits seed the remainder
    always_comb
    begin
        dv0_next.vec = sq_d[SQ_STEPS].vec;
        dv0_next.len = sq_d[SQ_STEPS].root;
        for (int i = 0; i < 3; i++)
        begin
            dv0_next.num[i] = {1'b0, sq_d[SQ_STEPS].vec.mag[i], 14'd0}
                              + {15'd0, sq_d[SQ_STEPS].root[LEN_W-1:1]};
            dv0_next.rem[i] = {2'b00, dv0_next.num[i][NUM_W-1:QUO_W]};
            dv0_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v[0] <= 1'b0;
        else if (en)
            dv_v[0] <= sq_v[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_d[0] <= dv0_next;
    end

    // restoring division, one quotient bit per cell
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_dv
        tfn_dv_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (dv_v[k]),
            .din   (dv_d[k]),
            .vout  (dv_v[k+1]),
            .dout  (dv_d[k+1])
        );
    end

    // ---------------- result select ----------------
    // degenerate: (mag+2)>>2 saturated at 1.0; else the rounded quotient
    always_comb
    begin
        degen_c = !(dv_d[DIV_STEPS].len > {19'd0, min_length_reg});
        for (int i = 0; i < 3; i++)
        begin
            rs[i] = ({1'b0, dv_d[DIV_STEPS].vec.mag[i]} + 35'd2) >> 2;
            if (degen_c)
                pick[i] = (rs[i] > 35'd16384) ? 16'd16384 : rs[i][15:0];
            else
                pick[i] = {1'b0, dv_d[DIV_STEPS].quo[i]};
            res[i] = dv_d[DIV_STEPS].vec.neg[i] ? 16'(-pick[i]) : pick[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_v[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= res[0];
            ny_reg <= res[1];
            nz_reg <= res[2];
            dg_reg <= degen_c;
            lo_reg <= dv_d[DIV_STEPS].vec.last;
        end
    end

    assign norm_out.valid      = ov_reg;
    assign norm_out.normal_x   = nx_reg;
    assign norm_out.normal_y   = ny_reg;
    assign norm_out.normal_z   = nz_reg;
    assign norm_out.degenerate = dg_reg;
    assign norm_out.last_out   = lo_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_range, ov_reg, nx_reg <= 16384 && nx_reg >= -16384 && ny_reg <= 16384 && ny_reg >= -16384 && nz_reg <= 16384 && nz_reg >= -16384, "normal out of range")
    `ASSERT_IMPL(a_unit, ov_reg && !dg_reg, nx_reg > 8192 || nx_reg < -8192 || ny_reg > 8192 || ny_reg < -8192 || nz_reg > 8192 || nz_reg < -8192, "normalized vector too short")
    `ASSERT_IMPL(a_sqrem, sq_v[SQ_STEPS], sq_d[SQ_STEPS].rem <= {2'b00, sq_d[SQ_STEPS].root, 1'b0}, "root remainder too large")

endmodule

// ===== hdl/tfn_front.sv =====
module tfn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tfn_pkg::tfn_ctl_t ctl,
    input  tfn_pkg::tfn_tri_t tri_d,
    output logic              vout,
    output tfn_pkg::tfn_sq_t  dout
);
    import tfn_pkg::*;

    // s1 edges
    logic               v1_reg;
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic               l1_reg;
    // s2 products
    logic               v2_reg;
    logic signed [33:0] p_reg [6];
    logic               l2_reg;
    // s3 cross product
    logic               v3_reg;
    tfn_vec_t           vec3_reg;
    // s4 partial squares
    logic               v4_reg;
    tfn_vec_t           vec4_reg;
    logic [33:0]        hh_reg [3];
    logic [33:0]        hl_reg [3];
    logic [33:0]        ll_reg [3];
    // s5 squares
    logic               v5_reg;
    tfn_vec_t           vec5_reg;
    logic [67:0]        sq_reg [3];
    // s6 sum
    logic               v6_reg;
    tfn_vec_t           vec6_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic signed [16:0] a_s [3];
    logic signed [16:0] b_s [3];
    logic signed [16:0] c_s [3];
    logic signed [34:0] n_c [3];
    tfn_vec_t           vec3_next;

    always_comb
    begin
        a_s[0] = {tri_d.ax[15], tri_d.ax};
        a_s[1] = {tri_d.ay[15], tri_d.ay};
        a_s[2] = {tri_d.az[15], tri_d.az};
        b_s[0] = {tri_d.bx[15], tri_d.bx};
        b_s[1] = {tri_d.by[15], tri_d.by};
        b_s[2] = {tri_d.bz[15], tri_d.bz};
        c_s[0] = {tri_d.cx[15], tri_d.cx};
        c_s[1] = {tri_d.cy[15], tri_d.cy};
        c_s[2] = {tri_d.cz[15], tri_d.cz};
    end

    always_comb
    begin
        n_c[0] = {p_reg[0][33], p_reg[0]} - {p_reg[1][33], p_reg[1]};
        n_c[1] = {p_reg[2][33], p_reg[2]} - {p_reg[3][33], p_reg[3]};
        n_c[2] = {p_reg[4][33], p_reg[4]} - {p_reg[5][33], p_reg[5]};
        vec3_next.last = l2_reg;
        for (int i = 0; i < 3; i++)
        begin
            vec3_next.neg[i] = n_c[i][34];
            vec3_next.mag[i] = n_c[i][34] ? 34'(-n_c[i]) : n_c[i][33:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= b_s[i] - a_s[i];
                e2_reg[i] <= c_s[i] - a_s[i];
            end
            l1_reg   <= tri_d.last;
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            l2_reg   <= l1_reg;
            vec3_reg <= vec3_next;
            vec4_reg <= vec3_reg;
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= vec3_reg.mag[i][33:17] * vec3_reg.mag[i][33:17];
                hl_reg[i] <= vec3_reg.mag[i][33:17] * vec3_reg.mag[i][16:0];
                ll_reg[i] <= vec3_reg.mag[i][16:0] * vec3_reg.mag[i][16:0];
                sq_reg[i] <= {hh_reg[i], 34'd0} + {16'd0, hl_reg[i], 18'd0}
                             + {34'd0, ll_reg[i]};
            end
            vec5_reg <= vec4_reg;
            vec6_reg <= vec5_reg;
            sum_reg  <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        end
    end

    assign vout      = v6_reg;
    assign dout.vec  = vec6_reg;
    assign dout.sum  = sum_reg;
    assign dout.rem  = '0;
    assign dout.root = '0;

endmodule

// ===== hdl/tfn_sq_cell.sv =====
// One root bit per cell: bring down two radicand bits, try root*4+1.
module tfn_sq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  tfn_pkg::tfn_sq_t din,
    output logic             vout,
    output tfn_pkg::tfn_sq_t dout
);
    import tfn_pkg::*;

    logic             v_reg;
    tfn_sq_t          d_reg;
    tfn_sq_t          d_next;
    logic [SREM_W-1:0] r2;
    logic [SREM_W-1:0] trial;

    always_comb
    begin
        r2             = {din.rem[SREM_W-3:0], din.sum[SUM_W-1 -: 2]};
        trial          = {1'b0, din.root, 2'b01};
        d_next.vec     = din.vec;
        d_next.sum     = {din.sum[SUM_W-3:0], 2'b00};
        if (r2 >= trial)
        begin
            d_next.rem  = r2 - trial;
            d_next.root = {din.root[LEN_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem  = r2;
            d_next.root = {din.root[LEN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

// ===== hdl/tfn_dv_cell.sv =====
// One quotient bit per cell for all three components (restoring).
module tfn_dv_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  tfn_pkg::tfn_dv_t din,
    output logic             vout,
    output tfn_pkg::tfn_dv_t dout
);
    import tfn_pkg::*;

    logic              v_reg;
    tfn_dv_t           d_reg;
    tfn_dv_t           d_next;
    logic [DREM_W-1:0] r2 [3];

    always_comb
    begin
        d_next.vec = din.vec;
        d_next.len = din.len;
        for (int i = 0; i < 3; i++)
        begin
            r2[i]          = {din.rem[i][DREM_W-2:0], din.num[i][QUO_W-1]};
            d_next.num[i]  = {din.num[i][NUM_W-2:0], 1'b0};
            if (r2[i] >= {1'b0, din.len})
            begin
                d_next.rem[i] = r2[i] - {1'b0, din.len};
                d_next.quo[i] = {din.quo[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                d_next.rem[i] = r2[i];
                d_next.quo[i] = {din.quo[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule
